FILE: hdl/gtpu_pkg.sv
// shared types and constants of the graphics tag packet unpacker
package gtpu_pkg;

  localparam int unsigned MAX_DESCRIPTORS = 16;
  localparam int unsigned DescW = 4;
  localparam int unsigned IdxW = $clog2(MAX_DESCRIPTORS);
  localparam int unsigned RplW = IdxW + 1;
  localparam int unsigned LoopW = 15;

  localparam logic [7:0] IMAGE_REG = 8'h54;

  localparam logic [1:0] FmtPacked = 2'd0;
  localparam logic [1:0] FmtRegList = 2'd1;
  localparam logic [1:0] FmtImageA = 2'd2;
  localparam logic [1:0] FmtImageB = 2'd3;

  typedef struct packed {
    logic [63:0] quad_lo;
    logic [63:0] quad_hi;
    logic        burst_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  reg_addr;
    logic [63:0] reg_data;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [LoopW-1:0]                          loops_left;
    logic [1:0]                                data_format;
    logic [RplW-1:0]                           regs_per_loop;
    logic [IdxW-1:0]                           desc_index;
    logic [MAX_DESCRIPTORS-1:0][DescW-1:0]     descriptors;
  } unpk_state_t;

  typedef struct packed {
    logic [1:0]  count;
    out_item_t   res0;
    out_item_t   res1;
    unpk_state_t nxt;
  } dec_res_t;

  typedef struct packed {
    logic       can_load;
    logic [1:0] count;
  } buf_status_t;

endpackage

FILE: hdl/gtpu_decode.sv
// decodes one quadword against the current tag state into up to two register writes
module gtpu_decode (
  input  gtpu_pkg::unpk_state_t st_i,
  input  gtpu_pkg::in_item_t    item_i,
  output gtpu_pkg::dec_res_t    dec_o
);

  logic                       is_tag;
  logic [gtpu_pkg::RplW-1:0]  tag_n;
  logic [gtpu_pkg::RplW-1:0]  nx0;
  logic [gtpu_pkg::RplW-1:0]  nx1;
  logic [gtpu_pkg::IdxW-1:0]  idx1;
  logic [gtpu_pkg::LoopW-1:0] loops1;
  logic                       wrap0;
  logic                       wrap1;
  logic                       done;

  assign is_tag = (st_i.loops_left == '0) || item_i.burst_start;
  assign tag_n  = (item_i.quad_lo[63:60] == '0) ? gtpu_pkg::RplW'(gtpu_pkg::MAX_DESCRIPTORS)
                                                : {1'b0, item_i.quad_lo[63:60]};

  // first write: advance descriptor index, wrap consumes one loop
  assign nx0    = {1'b0, st_i.desc_index} + gtpu_pkg::RplW'(1);
  assign wrap0  = (nx0 >= st_i.regs_per_loop);
  assign loops1 = wrap0 ? st_i.loops_left - gtpu_pkg::LoopW'(1) : st_i.loops_left;
  assign done   = wrap0 && (loops1 == '0);
  assign idx1   = wrap0 ? gtpu_pkg::IdxW'(nx0 - st_i.regs_per_loop)
                        : gtpu_pkg::IdxW'(nx0);
  assign nx1    = {1'b0, idx1} + gtpu_pkg::RplW'(1);
  assign wrap1  = (nx1 >= st_i.regs_per_loop);

  always_comb begin
    dec_o       = '0;
    dec_o.nxt   = st_i;
    dec_o.res0  = '0;
    dec_o.res1  = '0;
    dec_o.count = 2'd0;
    if (is_tag) begin
      dec_o.nxt.loops_left    = item_i.quad_lo[gtpu_pkg::LoopW-1:0];
      dec_o.nxt.data_format   = item_i.quad_lo[59:58];
      dec_o.nxt.regs_per_loop = tag_n;
      dec_o.nxt.desc_index    = '0;
      for (int i = 0; i < gtpu_pkg::MAX_DESCRIPTORS; i++) begin
        dec_o.nxt.descriptors[i] = (gtpu_pkg::RplW'(i) < tag_n)
                                   ? item_i.quad_hi[i*gtpu_pkg::DescW +: gtpu_pkg::DescW]
                                   : '0;
      end
    end else begin
      unique case (st_i.data_format) inside
        gtpu_pkg::FmtPacked: begin
          dec_o.count         = 2'd1;
          dec_o.res0.reg_addr = item_i.quad_hi[7:0];
          dec_o.res0.reg_data = item_i.quad_lo;
          dec_o.res0.last     = 1'b1;
          dec_o.nxt.loops_left = loops1;
          dec_o.nxt.desc_index = wrap0 ? '0 : gtpu_pkg::IdxW'(nx0);
        end
        gtpu_pkg::FmtRegList: begin
          dec_o.res0.reg_addr = {4'd0, st_i.descriptors[st_i.desc_index]};
          dec_o.res0.reg_data = item_i.quad_lo;
          if (done) begin
            dec_o.count          = 2'd1;
            dec_o.res0.last      = 1'b1;
            dec_o.nxt.loops_left = loops1;
            dec_o.nxt.desc_index = idx1;
          end else begin
            dec_o.count          = 2'd2;
            dec_o.res0.last      = 1'b0;
            dec_o.res1.reg_addr  = {4'd0, st_i.descriptors[idx1]};
            dec_o.res1.reg_data  = item_i.quad_hi;
            dec_o.res1.last      = 1'b1;
            dec_o.nxt.loops_left = wrap1 ? loops1 - gtpu_pkg::LoopW'(1) : loops1;
            dec_o.nxt.desc_index = wrap1 ? gtpu_pkg::IdxW'(nx1 - st_i.regs_per_loop)
                                         : gtpu_pkg::IdxW'(nx1);
          end
        end
        gtpu_pkg::FmtImageA, gtpu_pkg::FmtImageB: begin
          dec_o.count          = 2'd2;
          dec_o.res0.reg_addr  = gtpu_pkg::IMAGE_REG;
          dec_o.res0.reg_data  = item_i.quad_lo;
          dec_o.res0.last      = 1'b0;
          dec_o.res1.reg_addr  = gtpu_pkg::IMAGE_REG;
          dec_o.res1.reg_data  = item_i.quad_hi;
          dec_o.res1.last      = 1'b1;
          dec_o.nxt.loops_left = st_i.loops_left - gtpu_pkg::LoopW'(1);
        end
        default: begin
          dec_o.count = 2'd0;
        end
      endcase
    end
  end

endmodule

FILE: hdl/gtpu_out_buf.sv
// two-entry result buffer that hands register writes out one per cycle while out_stall_i is low
module gtpu_out_buf (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  gtpu_pkg::dec_res_t      dec_i,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output gtpu_pkg::out_item_t     out_item_o,
  output gtpu_pkg::buf_status_t   status_o
);

  logic [1:0]          cnt_q, cnt_d;
  gtpu_pkg::out_item_t slot0_q, slot0_d;
  gtpu_pkg::out_item_t slot1_q, slot1_d;
  logic                out_acc;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = slot0_q;
  assign out_acc     = out_valid_o && !out_stall_i;

  // a load only lands when the buffer is empty or drains this cycle
  assign status_o.can_load = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && !out_stall_i);
  assign status_o.count    = cnt_q;

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (out_acc) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
    end
    if (load_i) begin
      cnt_d   = dec_i.count;
      slot0_d = dec_i.res0;
      slot1_d = dec_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

FILE: hdl/graphics_tag_packet_unpacker_unit.sv
// top level of the graphics tag packet unpacker: input register, tag state, result buffer
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid_i/in_stall_o   | in_item_i  (quad_lo, quad_hi, burst_start)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (reg_addr, reg_data, last)
//
// a request is held in the input register, then is decoded in one pass
// a quadword that makes two writes fills the two-entry buffer, which drains them one write
// at a time through the single result port
// reset clears the tag state, so the first quadword after reset is a tag
// an output stall backs up into the input register and then into in_stall_o
module graphics_tag_packet_unpacker_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gtpu_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gtpu_pkg::out_item_t out_item_o
);

  logic                  in_valid_q;
  gtpu_pkg::in_item_t    item_q;
  gtpu_pkg::unpk_state_t st_q;
  gtpu_pkg::dec_res_t    dec;
  gtpu_pkg::buf_status_t buf_st;
  logic                  process;
  logic                  load;

  gtpu_decode u_decode (
    .st_i   (st_q),
    .item_i (item_q),
    .dec_o  (dec)
  );

  // tags make no writes and never wait on the buffer
  assign process    = in_valid_q && ((dec.count == 2'd0) || buf_st.can_load);
  assign load       = process && (dec.count != 2'd0);
  assign in_stall_o = in_valid_q && !process;

  gtpu_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .dec_i       (dec),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .status_o    (buf_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      st_q       <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (process) begin
        st_q <= dec.nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      item_q <= in_item_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_st.count != 2'd3)
    else $error("result buffer count out of range");

  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (buf_st.count == 2'd1)) |-> out_item_o.last)
    else $error("final buffered write lacks last");

  a_drain_by_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_valid_o && !out_stall_i))
    else $error("result dropped without being taken");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> ((buf_st.count == 2'd0) || ((buf_st.count == 2'd1) && !out_stall_i)))
    else $error("buffer loaded over a pending write");

endmodule
